### design/mna_pkg.sv
// ----------------------------------------------------------------------------
// MIDI NRPN assembler package
// Shared types, register map and code constants for the NRPN assembler.
// ----------------------------------------------------------------------------
package mna_pkg;

    // Register port geometry.
    localparam int REG_ADDR_W = 5;
    localparam int REG_DATA_W = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_OWN_CHANNEL    = 3'd0;
    localparam logic [2:0] REG_EXPOSED_LIMIT  = 3'd1;
    localparam logic [2:0] REG_CC_NUMBER_HIGH = 3'd2;
    localparam logic [2:0] REG_CC_NUMBER_LOW  = 3'd3;
    localparam logic [2:0] REG_CC_VALUE_HIGH  = 3'd4;
    localparam logic [2:0] REG_CC_VALUE_LOW   = 3'd5;

    // Register reset values.
    localparam logic [3:0]  RST_OWN_CHANNEL    = 4'd0;
    localparam logic [13:0] RST_EXPOSED_LIMIT  = 14'd184;
    localparam logic [6:0]  RST_CC_NUMBER_HIGH = 7'd99;
    localparam logic [6:0]  RST_CC_NUMBER_LOW  = 7'd98;
    localparam logic [6:0]  RST_CC_VALUE_HIGH  = 7'd6;
    localparam logic [6:0]  RST_CC_VALUE_LOW   = 7'd38;

    // Input function codes.
    localparam logic FUNC_MESSAGE = 1'b0;
    localparam logic FUNC_EOB     = 1'b1;

    // Result kind codes.
    localparam logic [1:0] KIND_PASSED  = 2'd0;
    localparam logic [1:0] KIND_EXPOSED = 2'd1;
    localparam logic [1:0] KIND_OTHER   = 2'd2;

    // Upper nibble of a control change status byte.
    localparam logic [3:0] CC_STATUS_NIBBLE = 4'hB;

    // Received-flag positions.
    localparam int PART_NH = 0;
    localparam int PART_NL = 1;
    localparam int PART_VH = 2;
    localparam int PART_VL = 3;

    // Configuration register contents.
    typedef struct packed {
        logic [3:0]  own_channel;
        logic [13:0] exposed_limit;
        logic [6:0]  cc_number_high;
        logic [6:0]  cc_number_low;
        logic [6:0]  cc_value_high;
        logic [6:0]  cc_value_low;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic        func;
        logic [7:0]  status;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [15:0] time_stamp;
    } in_item_t;

    // One entry of the hold store.
    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [15:0] time_stamp;
    } held_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic apply_msg;
        logic emit_msg;
        logic emit_nrpn;
        logic start_replay;
        logic emit_replay;
        logic replay_next;
        logic finish_buffer;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_eob;
        logic hold_ok;
        logic all_parts;
        logic held_empty;
        logic replay_last;
        logic out_free;
    } stat_t;

endpackage

### design/mna_in_if.sv
// ----------------------------------------------------------------------------
// MIDI NRPN assembler input channel
// Valid/ready channel carrying one MIDI message or an end-of-buffer mark.
// ----------------------------------------------------------------------------
interface mna_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  status;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [15:0] time_stamp;

    modport source (
        output valid,
        output func,
        output status,
        output data_one,
        output data_two,
        output time_stamp,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  status,
        input  data_one,
        input  data_two,
        input  time_stamp,
        output ready
    );
endinterface

### design/mna_out_if.sv
// ----------------------------------------------------------------------------
// MIDI NRPN assembler output channel
// Valid/ready channel carrying a passed message or an assembled NRPN.
// ----------------------------------------------------------------------------
interface mna_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_status;
    logic [6:0]  out_data_one;
    logic [6:0]  out_data_two;
    logic [15:0] out_time_stamp;
    logic [13:0] nrpn_number;
    logic [13:0] nrpn_value;
    logic        last;

    modport source (
        output valid,
        output kind,
        output out_status,
        output out_data_one,
        output out_data_two,
        output out_time_stamp,
        output nrpn_number,
        output nrpn_value,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  out_status,
        input  out_data_one,
        input  out_data_two,
        input  out_time_stamp,
        input  nrpn_number,
        input  nrpn_value,
        input  last,
        output ready
    );
endinterface

### design/mna_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
module mna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/mna_regs.sv
// ----------------------------------------------------------------------------
// MIDI NRPN assembler configuration registers
// APB-style register file holding channel, exposure limit and CC numbers.
// ----------------------------------------------------------------------------
module mna_regs
    import mna_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[REG_ADDR_W-1:2];

    // Register writes; indexes beyond the map are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_channel    <= RST_OWN_CHANNEL;
            cfg_reg.exposed_limit  <= RST_EXPOSED_LIMIT;
            cfg_reg.cc_number_high <= RST_CC_NUMBER_HIGH;
            cfg_reg.cc_number_low  <= RST_CC_NUMBER_LOW;
            cfg_reg.cc_value_high  <= RST_CC_VALUE_HIGH;
            cfg_reg.cc_value_low   <= RST_CC_VALUE_LOW;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OWN_CHANNEL:    cfg_reg.own_channel    <= pwdata[3:0];
                REG_EXPOSED_LIMIT:  cfg_reg.exposed_limit  <= pwdata[13:0];
                REG_CC_NUMBER_HIGH: cfg_reg.cc_number_high <= pwdata[6:0];
                REG_CC_NUMBER_LOW:  cfg_reg.cc_number_low  <= pwdata[6:0];
                REG_CC_VALUE_HIGH:  cfg_reg.cc_value_high  <= pwdata[6:0];
                REG_CC_VALUE_LOW:   cfg_reg.cc_value_low   <= pwdata[6:0];
                default:            ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_idx)
            REG_OWN_CHANNEL:    prdata = {28'd0, cfg_reg.own_channel};
            REG_EXPOSED_LIMIT:  prdata = {18'd0, cfg_reg.exposed_limit};
            REG_CC_NUMBER_HIGH: prdata = {25'd0, cfg_reg.cc_number_high};
            REG_CC_NUMBER_LOW:  prdata = {25'd0, cfg_reg.cc_number_low};
            REG_CC_VALUE_HIGH:  prdata = {25'd0, cfg_reg.cc_value_high};
            REG_CC_VALUE_LOW:   prdata = {25'd0, cfg_reg.cc_value_low};
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/mna_dp.sv
// ----------------------------------------------------------------------------
// MIDI NRPN assembler datapath
// Item register, NRPN part registers, hold store and output register.
// ----------------------------------------------------------------------------
module mna_dp
    import mna_pkg::*;
#(
    parameter int HOLD_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output stat_t     stat,
    mna_out_if.source out_ch
);

    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    in_item_t    item_reg;
    logic [6:0]  nh_part_reg;
    logic [6:0]  nl_part_reg;
    logic [6:0]  vh_part_reg;
    logic [6:0]  vl_part_reg;
    logic [3:0]  parts_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  status_reg;
    logic [6:0]  data_one_reg;
    logic [6:0]  data_two_reg;
    logic [15:0] time_stamp_reg;
    logic [13:0] number_reg;
    logic [13:0] value_reg;
    logic        last_reg;

    logic        is_cc;
    logic        hit_nh;
    logic        hit_nl;
    logic        hit_vh;
    logic        hit_vl;
    logic        is_nrpn;
    logic        hold_ok;
    logic        replay_last;
    logic [13:0] nrpn_number;
    logic [13:0] nrpn_value;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_raddr;
    held_t       ram_wdata;
    held_t       ram_rdata;
    logic        emit_any;

    // Classify the held item; the first matching controller number wins.
    assign is_cc   = (item_reg.status[7:4] == CC_STATUS_NIBBLE)
                  && (item_reg.status[3:0] == cfg.own_channel);
    assign hit_nh  = is_cc && (item_reg.data_one == cfg.cc_number_high);
    assign hit_nl  = is_cc && !hit_nh && (item_reg.data_one == cfg.cc_number_low);
    assign hit_vh  = is_cc && !hit_nh && !hit_nl
                  && (item_reg.data_one == cfg.cc_value_high);
    assign hit_vl  = is_cc && !hit_nh && !hit_nl && !hit_vh
                  && (item_reg.data_one == cfg.cc_value_low);
    assign is_nrpn = hit_nh || hit_nl || hit_vh || hit_vl;
    assign hold_ok = is_nrpn && (count_reg < CW'(HOLD_DEPTH));

    assign nrpn_number = {nh_part_reg, nl_part_reg};
    assign nrpn_value  = {vh_part_reg, vl_part_reg};
    assign replay_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign stat.is_eob      = (item_reg.func == FUNC_EOB);
    assign stat.hold_ok     = hold_ok;
    assign stat.all_parts   = &parts_reg;
    assign stat.held_empty  = (count_reg == '0);
    assign stat.replay_last = replay_last;
    assign stat.out_free    = !out_valid_reg || out_ch.ready;

    // Item capture register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
    end

    // NRPN parts, received flags, hold count and replay index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nh_part_reg <= '0;
            nl_part_reg <= '0;
            vh_part_reg <= '0;
            vl_part_reg <= '0;
            parts_reg   <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.apply_msg)
            begin
                if (hit_nh)
                begin
                    nh_part_reg        <= item_reg.data_two;
                    parts_reg[PART_NH] <= 1'b1;
                end
                if (hit_nl)
                begin
                    nl_part_reg        <= item_reg.data_two;
                    parts_reg[PART_NL] <= 1'b1;
                end
                if (hit_vh)
                begin
                    vh_part_reg        <= item_reg.data_two;
                    parts_reg[PART_VH] <= 1'b1;
                end
                if (hit_vl)
                begin
                    vl_part_reg        <= item_reg.data_two;
                    parts_reg[PART_VL] <= 1'b1;
                end
                if (hold_ok)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.finish_buffer)
            begin
                parts_reg <= '0;
                count_reg <= '0;
            end
            if (cmd.start_replay)
            begin
                idx_reg <= '0;
            end
            else if (cmd.replay_next)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // Hold store access.
    assign ram_we    = cmd.apply_msg && hold_ok;
    assign ram_wdata = '{status:     item_reg.status,
                         data_one:   item_reg.data_one,
                         data_two:   item_reg.data_two,
                         time_stamp: item_reg.time_stamp};
    assign ram_re    = cmd.start_replay || cmd.replay_next;
    assign ram_raddr = cmd.start_replay ? '0 : idx_reg + AW'(1);

    mna_ram #(
        .WIDTH ($bits(held_t)),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register valid flag.
    assign emit_any = cmd.emit_msg || cmd.emit_nrpn || cmd.emit_replay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_msg)
        begin
            kind_reg       <= KIND_PASSED;
            status_reg     <= item_reg.status;
            data_one_reg   <= item_reg.data_one;
            data_two_reg   <= item_reg.data_two;
            time_stamp_reg <= item_reg.time_stamp;
            number_reg     <= '0;
            value_reg      <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_nrpn)
        begin
            kind_reg       <= (nrpn_number < cfg.exposed_limit) ? KIND_EXPOSED : KIND_OTHER;
            status_reg     <= '0;
            data_one_reg   <= '0;
            data_two_reg   <= '0;
            time_stamp_reg <= '0;
            number_reg     <= nrpn_number;
            value_reg      <= nrpn_value;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_replay)
        begin
            kind_reg       <= KIND_PASSED;
            status_reg     <= ram_rdata.status;
            data_one_reg   <= ram_rdata.data_one;
            data_two_reg   <= ram_rdata.data_two;
            time_stamp_reg <= ram_rdata.time_stamp;
            number_reg     <= '0;
            value_reg      <= '0;
            last_reg       <= replay_last;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.kind           = kind_reg;
    assign out_ch.out_status     = status_reg;
    assign out_ch.out_data_one   = data_one_reg;
    assign out_ch.out_data_two   = data_two_reg;
    assign out_ch.out_time_stamp = time_stamp_reg;
    assign out_ch.nrpn_number    = number_reg;
    assign out_ch.nrpn_value     = value_reg;
    assign out_ch.last           = last_reg;

endmodule

### design/mna_ctrl.sv
// ----------------------------------------------------------------------------
// MIDI NRPN assembler controller
// State machine that sequences item intake, processing and replay.
// ----------------------------------------------------------------------------
module mna_ctrl
    import mna_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_PROCESS = 3'b010,
        ST_REPLAY  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PROCESS;
                end
            end
            ST_PROCESS:
            begin
                if (stat.is_eob)
                begin
                    // End of buffer: NRPN result, replay or nothing.
                    if (stat.all_parts)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit_nrpn     = 1'b1;
                            cmd.finish_buffer = 1'b1;
                            state_next        = ST_IDLE;
                        end
                    end
                    else if (stat.held_empty)
                    begin
                        cmd.finish_buffer = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        cmd.start_replay = 1'b1;
                        state_next       = ST_REPLAY;
                    end
                end
                else if (stat.hold_ok)
                begin
                    cmd.apply_msg = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    // Passed message; parts still update when the store is full.
                    cmd.apply_msg = 1'b1;
                    cmd.emit_msg  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REPLAY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_replay = 1'b1;
                    if (stat.replay_last)
                    begin
                        cmd.finish_buffer = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        cmd.replay_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/midi_nrpn_assembler_core.sv
// ----------------------------------------------------------------------------
// MIDI NRPN assembler core
// Assembles NRPN control-change sequences per buffer, passing other traffic.
// ----------------------------------------------------------------------------
// Usage:
// - in_ch carries MIDI messages (func = 0) and end-of-buffer marks (func = 1).
// - out_ch carries passed messages (kind 0) and assembled NRPNs (kind 1, 2);
//   last marks the final result caused by one input transfer.
// - The APB port sets the channel, exposure limit and the four CC numbers;
//   write it only while the block is idle.
// Timing:
// - An input transfer is followed by a processing state before the next item
//   is taken; a passed message or NRPN is registered into the output register
//   from that state, and a replay starts with a read of the hold RAM.
// - An end of buffer that replays held messages starts with one hold RAM
//   read, then one message per cycle from the RAM port while out_ch is free.
// Reset clears the NRPN parts, received flags and hold count and loads the
// register defaults; the hold RAM needs no clearing. When out_ch stalls, the
// output register keeps its result; held NRPN messages still go on, and any
// result that needs the output register waits in place until it frees up.
// ----------------------------------------------------------------------------
module midi_nrpn_assembler_core
    import mna_pkg::*;
#(
    parameter int HOLD_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mna_in_if.sink                in_ch,
    mna_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t     cfg;
    cmd_t     cmd;
    stat_t    stat;
    in_item_t in_item;
    logic     in_ready;

    // Gather the input payload.
    assign in_item = '{func:       in_ch.func,
                       status:     in_ch.status,
                       data_one:   in_ch.data_one,
                       data_two:   in_ch.data_two,
                       time_stamp: in_ch.time_stamp};
    assign in_ch.ready = in_ready;

    mna_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mna_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_item (in_item),
        .cmd     (cmd),
        .stat    (stat),
        .out_ch  (out_ch)
    );

endmodule
